[sv/spot_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spot_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int COORD_W     = 32;
   localparam int RATIO_W     = 17;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = COORD_W + RATIO_W;
   localparam int MIDX_W      = 8;

   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(32768);

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type ref_start;
      coord_type ref_end;
      coord_type qry_start;
      coord_type qry_end;
   } pair_type;

   // control from the sequencer to the compare stages
   typedef struct packed {
      logic             clear;
      logic             valid;
      logic [IDX_W-1:0] index;
   } scan_ctl_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] index;
   } match_type;

   // closed-interval intersection
   function automatic logic intervals_meet(coord_type a_lo, coord_type a_hi,
                                           coord_type b_lo, coord_type b_hi);
      return (a_lo >= b_lo && a_lo <= b_hi) || (a_hi >= b_lo && a_hi <= b_hi) ||
             (a_lo <= b_lo && a_hi >= b_hi);
   endfunction

   function automatic coord_type overlap_len(coord_type a_lo, coord_type a_hi,
                                             coord_type b_lo, coord_type b_hi);
      coord_type lo;
      coord_type hi;
      lo = (a_lo > b_lo) ? a_lo : b_lo;
      hi = (a_hi < b_hi) ? a_hi : b_hi;
      return (hi >= lo) ? (hi - lo) : '0;
   endfunction

endpackage

`default_nettype wire

[sv/spot_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface spot_req_if;
   import spot_pkg::*;

   logic      valid;
   logic      ready;
   logic      opcode;
   coord_type ref_start;
   coord_type ref_end;
   coord_type qry_start;
   coord_type qry_end;

   modport source (output valid, opcode, ref_start, ref_end, qry_start, qry_end,
                   input ready);
   modport sink (input valid, opcode, ref_start, ref_end, qry_start, qry_end,
                 output ready);
endinterface

`default_nettype wire

[sv/spot_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface spot_rsp_if;
   import spot_pkg::*;

   logic              valid;
   logic              ready;
   logic              found;
   logic [MIDX_W-1:0] match_index;
   logic              inserted;
   logic              table_full;
   logic              zero_size;

   modport source (output valid, found, match_index, inserted, table_full, zero_size,
                   input ready);
   modport sink (input valid, found, match_index, inserted, table_full, zero_size,
                 output ready);
endinterface

`default_nettype wire

[sv/spot_csr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface spot_csr_if;
   import spot_pkg::*;

   logic               valid;
   logic               ready;
   logic [RATIO_W-1:0] overlap_ratio;

   modport source (output valid, overlap_ratio, input ready);
   modport sink (input valid, overlap_ratio, output ready);
endinterface

`default_nettype wire

[sv/spot_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module spot_cell (
   input  wire logic             clock,
   input  wire logic             shift_en,
   input  wire spot_pkg::pair_type shift_data,
   input  wire logic             load_en,
   input  wire spot_pkg::pair_type load_data,
   output spot_pkg::pair_type    entry
);
   import spot_pkg::*;

   pair_type entry_ff;
   pair_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_data;
      end else if (shift_en) begin
         entry_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

[sv/spot_ring.sv]
`timescale 1ns / 1ps
`default_nettype none

module spot_ring (
   input  wire logic                      clock,
   input  wire logic                      shift_en,
   input  wire logic                      load_en,
   input  wire logic [spot_pkg::IDX_W-1:0] load_index,
   input  wire spot_pkg::pair_type        load_data,
   output spot_pkg::pair_type             head
);
   import spot_pkg::*;

   pair_type cell_q [TABLE_DEPTH];

   // each cell takes its upper neighbor, the last one wraps to the head
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      spot_cell u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .shift_data (cell_q[(i + 1) % TABLE_DEPTH]),
         .load_en    (load_en && (load_index == IDX_W'(i))),
         .load_data  (load_data),
         .entry      (cell_q[i])
      );
   end

   assign head = cell_q[0];

endmodule

`default_nettype wire

[sv/spot_match.sv]
`timescale 1ns / 1ps
`default_nettype none

module spot_match (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire spot_pkg::scan_ctl_type     ctl,
   input  wire spot_pkg::pair_type         head,
   input  wire spot_pkg::pair_type         probe,
   input  wire logic [spot_pkg::PROD_W-1:0] prod_ref,
   input  wire logic [spot_pkg::PROD_W-1:0] prod_qry,
   output spot_pkg::match_type             result
);
   import spot_pkg::*;

   // stage a: intersection and overlap lengths
   logic             valid_ff, valid_in;
   logic             meet_ff, meet_in;
   coord_type        ovr_ff, ovr_in;
   coord_type        ovq_ff, ovq_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   // stage b: first qualifying entry
   match_type        match_ff, match_in;

   logic ok_ref;
   logic ok_qry;

   always_comb begin
      valid_in = ctl.clear ? 1'b0 : ctl.valid;
      meet_in  = intervals_meet(probe.ref_start, probe.ref_end, head.ref_start, head.ref_end)
              && intervals_meet(probe.qry_start, probe.qry_end, head.qry_start, head.qry_end);
      ovr_in   = overlap_len(probe.ref_start, probe.ref_end, head.ref_start, head.ref_end);
      ovq_in   = overlap_len(probe.qry_start, probe.qry_end, head.qry_start, head.qry_end);
      idx_in   = ctl.index;
   end

   // overlap * 65536 <= ratio * length
   assign ok_ref = PROD_W'({ovr_ff, {FRAC_W{1'b0}}}) <= prod_ref;
   assign ok_qry = PROD_W'({ovq_ff, {FRAC_W{1'b0}}}) <= prod_qry;

   always_comb begin
      match_in = match_ff;
      if (ctl.clear) begin
         match_in = '0;
      end else if (valid_ff && !match_ff.found && meet_ff && ok_ref && ok_qry) begin
         match_in.found = 1'b1;
         match_in.index = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      meet_ff <= meet_in;
      ovr_ff  <= ovr_in;
      ovq_ff  <= ovq_in;
      idx_ff  <= idx_in;
   end

   assign result = match_ff;

endmodule

`default_nettype wire

[sv/segment_pair_overlap_table_core.sv]
// channel   dir  handshake     payload
// req_chan  in   valid/ready   opcode, ref_start, ref_end, qry_start, qry_end
// rsp_chan  out  valid/ready   found, match_index, inserted, table_full, zero_size
// csr_chan  in   valid/ready   overlap_ratio (ready always high)
//
// from accept to response valid, a request waits on one full turn of the entry ring
// past the single compare unit
// a zero-size request answers with no ring turn
// reset (synchronous) empties the table and sets overlap_ratio to 32768
// one request at a time; the next one is taken while the response still waits,
// and a stalled response holds the sequencer before the table is updated
`timescale 1ns / 1ps
`default_nettype none

module segment_pair_overlap_table_core (
   input  wire logic   clock,
   input  wire logic   reset,
   spot_req_if.sink    req_chan,
   spot_rsp_if.source  rsp_chan,
   spot_csr_if.sink    csr_chan
);
   import spot_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_SCAN,
      S_DRAIN,
      S_FIN
   } state_type;

   state_type          state_ff, state_in;
   pair_type           pair_ff, pair_in;          // request being worked on
   logic               op_ff, op_in;
   logic               zero_ff, zero_in;
   coord_type          rlen_ff, rlen_in;
   coord_type          qlen_ff, qlen_in;
   logic [PROD_W-1:0]  prod_r_ff, prod_r_in;      // ratio * reference length
   logic [PROD_W-1:0]  prod_q_ff, prod_q_in;      // ratio * query length
   logic [IDX_W-1:0]   step_ff, step_in;          // entry now at the ring head
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;

   // response holding register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [MIDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic              rsp_ins_ff, rsp_ins_in;
   logic              rsp_full_ff, rsp_full_in;
   logic              rsp_zero_ff, rsp_zero_in;

   pair_type     new_pair;
   logic         new_zero;
   logic         req_accept;
   logic         out_free;
   logic         room;
   logic         want_insert;
   logic         shift_en;
   logic         load_en;
   pair_type     head;
   scan_ctl_type scan_ctl;
   match_type    match;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign new_pair.ref_start = req_chan.ref_start;
   assign new_pair.ref_end   = req_chan.ref_end;
   assign new_pair.qry_start = req_chan.qry_start;
   assign new_pair.qry_end   = req_chan.qry_end;
   // empty or reversed interval on either axis
   assign new_zero = (req_chan.ref_end <= req_chan.ref_start) ||
                     (req_chan.qry_end <= req_chan.qry_start);

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign room        = count_ff < CNT_W'(TABLE_DEPTH);
   assign want_insert = !zero_ff && op_ff && !match.found;

   // compare stage control: only entries below the fill count are tested
   assign scan_ctl.clear = req_accept;
   assign scan_ctl.valid = (state_ff == S_SCAN) && (CNT_W'(step_ff) < count_ff);
   assign scan_ctl.index = step_ff;

   // the ring turns once per scanned request, so entries come back to their places
   assign shift_en = (state_ff == S_SCAN);

   always_comb begin
      state_in     = state_ff;
      pair_in      = pair_ff;
      op_in        = op_ff;
      zero_in      = zero_ff;
      rlen_in      = rlen_ff;
      qlen_in      = qlen_ff;
      prod_r_in    = prod_r_ff;
      prod_q_in    = prod_q_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      ratio_in     = ratio_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_ins_in   = rsp_ins_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_zero_in  = rsp_zero_ff;
      load_en      = 1'b0;

      if (csr_chan.valid) begin
         ratio_in = csr_chan.overlap_ratio;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               pair_in  = new_pair;
               op_in    = req_chan.opcode;
               zero_in  = new_zero;
               rlen_in  = req_chan.ref_end - req_chan.ref_start;
               qlen_in  = req_chan.qry_end - req_chan.qry_start;
               state_in = new_zero ? S_FIN : S_MUL;
            end
         end
         S_MUL: begin
            prod_r_in = PROD_W'(ratio_ff) * PROD_W'(rlen_ff);
            prod_q_in = PROD_W'(ratio_ff) * PROD_W'(qlen_ff);
            step_in   = '0;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            step_in = step_ff + IDX_W'(1);
            if (step_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last entry's compare settles here
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = match.found;
               rsp_index_in = MIDX_W'(match.index);
               rsp_ins_in   = want_insert && room;
               rsp_full_in  = want_insert && !room;
               rsp_zero_in  = zero_ff;
               if (want_insert && room) begin
                  load_en  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ratio_ff     <= RATIO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ratio_ff     <= ratio_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pair_ff      <= pair_in;
      op_ff        <= op_in;
      zero_ff      <= zero_in;
      rlen_ff      <= rlen_in;
      qlen_ff      <= qlen_in;
      prod_r_ff    <= prod_r_in;
      prod_q_ff    <= prod_q_in;
      step_ff      <= step_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_ins_ff   <= rsp_ins_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_zero_ff  <= rsp_zero_in;
   end

   // entry storage: one cell per table slot, appends land at the fill count
   spot_ring u_ring (
      .clock      (clock),
      .shift_en   (shift_en),
      .load_en    (load_en),
      .load_index (count_ff[IDX_W-1:0]),
      .load_data  (pair_ff),
      .head       (head)
   );

   // two-stage compare at the ring head
   spot_match u_match (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .head     (head),
      .probe    (pair_ff),
      .prod_ref (prod_r_ff),
      .prod_qry (prod_q_ff),
      .result   (match)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.match_index = rsp_index_ff;
   assign rsp_chan.inserted    = rsp_ins_ff;
   assign rsp_chan.table_full  = rsp_full_ff;
   assign rsp_chan.zero_size   = rsp_zero_ff;

endmodule

`default_nettype wire

[sv/spot_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module spot_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        found,
   input wire logic [spot_pkg::MIDX_W-1:0] match_index,
   input wire logic                        inserted,
   input wire logic                        table_full,
   input wire logic                        zero_size
);
   import spot_pkg::*;

   // stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({found, match_index, inserted, table_full, zero_size}))
      else $error("response changed while stalled");

   // a rejected pair reports nothing else
   a_zero_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && zero_size |-> !found && !inserted && !table_full)
      else $error("zero-size response with other flags");

   // a match never appends, and append and drop exclude each other
   a_found_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(found && (inserted || table_full)) && !(inserted && table_full))
      else $error("conflicting result flags");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !found |-> match_index == '0)
      else $error("index set without a match");

endmodule

bind segment_pair_overlap_table_core spot_checker u_spot_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .found       (rsp_chan.found),
   .match_index (rsp_chan.match_index),
   .inserted    (rsp_chan.inserted),
   .table_full  (rsp_chan.table_full),
   .zero_size   (rsp_chan.zero_size)
);

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import spot_pkg::*;

   // request opcodes
   localparam logic OP_FIND   = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam int RESET_CYCLES = 10;
   localparam int TAIL_CYCLES  = 300;    // one full ring turn plus margin
   localparam int STALL_LIMIT  = 20000;  // cycles with no handshake at all
   localparam int REPORT_LIMIT = 10;

   // ladder pairs sit in disjoint slots, one slot per insert
   localparam coord_type LADDER_REF  = 32'h4000_0000;
   localparam coord_type LADDER_QRY  = 32'h8000_0000;
   localparam coord_type LADDER_STEP = 32'h0000_1000;

   typedef enum logic [1:0] {ITEM_REQ, ITEM_CSR, ITEM_DRAIN} item_kind_type;
   typedef enum int {SPAN_SMALL, SPAN_WIDE, SPAN_TOP, SPAN_FLAT} span_mode_type;

   typedef struct {
      item_kind_type      kind;
      logic               opcode;
      pair_type           pair;
      logic [RATIO_W-1:0] ratio;
      int unsigned        gap;
   } stim_type;

   typedef struct packed {
      logic              found;
      logic [MIDX_W-1:0] match_index;
      logic              inserted;
      logic              table_full;
      logic              zero_size;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spot_req_if req_chan ();
   spot_rsp_if rsp_chan ();
   spot_csr_if csr_chan ();

   segment_pair_overlap_table_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the pair table and the ratio register
   coord_type          tab_ref_lo [TABLE_DEPTH];
   coord_type          tab_ref_hi [TABLE_DEPTH];
   coord_type          tab_qry_lo [TABLE_DEPTH];
   coord_type          tab_qry_hi [TABLE_DEPTH];
   int unsigned        held_count = 0;
   logic [RATIO_W-1:0] ratio_copy = RATIO_RESET;

   stim_type    stim_q[$];     // pending requests, ratio writes and drain points
   outcome_type outcome_q[$];  // predicted responses in request order

   int unsigned req_issued = 0;
   int unsigned req_taken = 0;
   int unsigned csr_issued = 0;
   int unsigned csr_taken = 0;
   int unsigned rsp_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned hold_off = 0;
   int unsigned stall_left = 0;
   int unsigned reset_count = 0;
   int unsigned stim_total = 0;
   int unsigned ladder_next = 0;

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // both intervals are well formed here, so closed intersection is simple
   function automatic logic spans_meet(coord_type a_lo, coord_type a_hi,
                                       coord_type b_lo, coord_type b_hi);
      return (a_lo <= b_hi) && (b_lo <= a_hi);
   endfunction

   function automatic logic [63:0] shared_len(coord_type a_lo, coord_type a_hi,
                                              coord_type b_lo, coord_type b_hi);
      coord_type lo;
      coord_type hi;
      lo = (a_lo > b_lo) ? a_lo : b_lo;
      hi = (a_hi < b_hi) ? a_hi : b_hi;
      return (hi >= lo) ? 64'(hi - lo) : 64'd0;
   endfunction

   // overlap / length <= ratio / 2^16, by cross multiplication
   function automatic logic within_ratio(logic [63:0] shared, logic [63:0] span_len);
      return (shared << FRAC_W) <= (64'(ratio_copy) * span_len);
   endfunction

   // scans the shadow table for the first qualifying pair, appends on an unmatched insert if there is room
   function automatic outcome_type scan_table(logic op, pair_type p);
      outcome_type res;
      logic [63:0] rlen;
      logic [63:0] qlen;
      int unsigned k;
      res = '0;
      if (p.ref_end <= p.ref_start || p.qry_end <= p.qry_start) begin
         // degenerate pair: no scan, no insert
         res.zero_size = 1'b1;
      end else begin
         rlen = 64'(p.ref_end - p.ref_start);
         qlen = 64'(p.qry_end - p.qry_start);
         for (k = 0; k < held_count && !res.found; k++) begin
            if (spans_meet(p.ref_start, p.ref_end, tab_ref_lo[k], tab_ref_hi[k]) &&
                spans_meet(p.qry_start, p.qry_end, tab_qry_lo[k], tab_qry_hi[k]) &&
                within_ratio(shared_len(p.ref_start, p.ref_end,
                                        tab_ref_lo[k], tab_ref_hi[k]), rlen) &&
                within_ratio(shared_len(p.qry_start, p.qry_end,
                                        tab_qry_lo[k], tab_qry_hi[k]), qlen)) begin
               res.found       = 1'b1;
               res.match_index = k[MIDX_W-1:0];
            end
         end
         if (op == OP_INSERT && !res.found) begin
            if (held_count < TABLE_DEPTH) begin
               tab_ref_lo[held_count] = p.ref_start;
               tab_ref_hi[held_count] = p.ref_end;
               tab_qry_lo[held_count] = p.qry_start;
               tab_qry_hi[held_count] = p.qry_end;
               held_count++;
               res.inserted = 1'b1;
            end else begin
               res.table_full = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------

   task automatic add_request(input logic op, input coord_type rs, input coord_type re,
                              input coord_type qs, input coord_type qe);
      stim_type item;
      int unsigned r;
      item.kind           = ITEM_REQ;
      item.opcode         = op;
      item.pair.ref_start = rs;
      item.pair.ref_end   = re;
      item.pair.qry_start = qs;
      item.pair.qry_end   = qe;
      item.ratio          = '0;
      r = $urandom_range(0, 99);
      // every fourth stretch of 30 requests goes back to back
      if (((stim_total / 30) % 4) == 1) item.gap = 0;
      else if (r < 55) item.gap = 0;
      else if (r < 85) item.gap = $urandom_range(1, 3);
      else if (r < 97) item.gap = $urandom_range(4, 30);
      else item.gap = $urandom_range(100, 700);
      stim_total++;
      stim_q.insert(stim_q.size(), item);
   endtask

   task automatic add_ratio(input logic [RATIO_W-1:0] value);
      stim_type item;
      item = '{kind: ITEM_CSR, opcode: 1'b0, pair: '0, ratio: value, gap: 0};
      stim_q.insert(stim_q.size(), item);
   endtask

   // sender holds until every response is back
   task automatic add_drain();
      stim_type item;
      item = '{kind: ITEM_DRAIN, opcode: 1'b0, pair: '0, ratio: '0, gap: 0};
      stim_q.insert(stim_q.size(), item);
   endtask

   function automatic span_mode_type draw_mode();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return SPAN_SMALL;
      else if (r < 80) return SPAN_WIDE;
      else if (r < 93) return SPAN_TOP;
      else return SPAN_FLAT;
   endfunction

   task automatic pick_span(input span_mode_type mode, output coord_type lo,
                            output coord_type hi);
      coord_type room;
      case (mode)
         SPAN_SMALL: begin
            // crowded low range, lots of partial overlap
            lo = $urandom_range(0, 4000);
            hi = lo + $urandom_range(1, 1500);
         end
         SPAN_WIDE: begin
            lo = $urandom;
            room = ~lo;
            hi = (room == 0) ? lo : lo + $urandom_range(1, room);
         end
         SPAN_TOP: begin
            lo = ~coord_type'($urandom_range(1, 5000));
            room = ~lo;
            hi = lo + $urandom_range(1, room);
         end
         default: begin
            // equal or reversed ends
            lo = $urandom;
            if (lo == 0 || $urandom_range(0, 1) == 0) hi = lo;
            else hi = lo - $urandom_range(1, (lo < 1000) ? lo : 1000);
         end
      endcase
   endtask

   task automatic add_ladder_insert();
      coord_type rb;
      coord_type qb;
      rb = LADDER_REF + ladder_next * LADDER_STEP;
      qb = LADDER_QRY + ladder_next * LADDER_STEP;
      ladder_next++;
      add_request(OP_INSERT, rb + $urandom_range(0, 255), rb + 32'h700 - $urandom_range(0, 255),
                  qb + $urandom_range(0, 255), qb + 32'h700 - $urandom_range(0, 255));
   endtask

   task automatic add_random_request();
      coord_type rs;
      coord_type re;
      coord_type qs;
      coord_type qe;
      coord_type rb;
      coord_type qb;
      int unsigned slot;
      logic op;
      op = ($urandom_range(0, 9) < 6) ? OP_INSERT : OP_FIND;
      if (ladder_next > 0 && $urandom_range(0, 99) < 15) begin
         // straddle one ladder slot in both axes, so deep indexes can match
         slot = $urandom_range(0, ladder_next - 1);
         rb = LADDER_REF + slot * LADDER_STEP;
         qb = LADDER_QRY + slot * LADDER_STEP;
         rs = rb - 32'h200 + $urandom_range(0, 32'hA00);
         re = rs + $urandom_range(1, 32'hC00);
         qs = qb - 32'h200 + $urandom_range(0, 32'hA00);
         qe = qs + $urandom_range(1, 32'hC00);
      end else begin
         pick_span(draw_mode(), rs, re);
         pick_span(draw_mode(), qs, qe);
      end
      add_request(op, rs, re, qs, qe);
   endtask

   // ---------------------------------------------------------------------
   // driver: reset, request and ratio channels, response ready, all on the
   // falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_proc
      stim_type head;
      int unsigned r;
      if (reset) begin
         reset_count++;
         if (reset_count == RESET_CYCLES) reset <= 1'b0;
         req_chan.valid <= 1'b0;
         csr_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         // sender: one transfer in flight at a time
         if (req_issued == req_taken && csr_issued == csr_taken) begin
            if (hold_off > 0) begin
               hold_off--;
            end else if (stim_q.size() > 0) begin
               head = stim_q[0];
               case (head.kind)
                  ITEM_REQ: begin
                     void'(stim_q.pop_front());
                     req_chan.opcode    <= head.opcode;
                     req_chan.ref_start <= head.pair.ref_start;
                     req_chan.ref_end   <= head.pair.ref_end;
                     req_chan.qry_start <= head.pair.qry_start;
                     req_chan.qry_end   <= head.pair.qry_end;
                     req_issued++;
                     hold_off = head.gap;
                  end
                  ITEM_CSR: begin
                     // ratio changes only while the block is idle
                     if (outcome_q.size() == 0) begin
                        void'(stim_q.pop_front());
                        csr_chan.overlap_ratio <= head.ratio;
                        csr_issued++;
                     end
                  end
                  default: begin
                     if (outcome_q.size() == 0) void'(stim_q.pop_front());
                  end
               endcase
            end
         end
         req_chan.valid <= (req_issued != req_taken);
         csr_chan.valid <= (csr_issued != csr_taken);

         // receiver: random stalls, with quiet stretches
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            r = (((rsp_seen / 25) % 4) == 1) ? 999 : $urandom_range(0, 999);
            if (r < 30) begin
               stall_left = $urandom_range(0, 4);
               rsp_chan.ready <= 1'b0;
            end else if (r < 32) begin
               stall_left = $urandom_range(50, 400);
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: sample handshakes on the rising edge, predict and check
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : observe_proc
      outcome_type seen;
      outcome_type want;
      pair_type    taken_pair;
      logic        moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_chan.valid && csr_chan.ready) begin
            ratio_copy = csr_chan.overlap_ratio;
            csr_taken++;
            moved = 1'b1;
         end
         if (req_chan.valid && req_chan.ready) begin
            taken_pair.ref_start = req_chan.ref_start;
            taken_pair.ref_end   = req_chan.ref_end;
            taken_pair.qry_start = req_chan.qry_start;
            taken_pair.qry_end   = req_chan.qry_end;
            outcome_q.insert(outcome_q.size(), scan_table(req_chan.opcode, taken_pair));
            req_taken++;
            moved = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.found       = rsp_chan.found;
            seen.match_index = rsp_chan.match_index;
            seen.inserted    = rsp_chan.inserted;
            seen.table_full  = rsp_chan.table_full;
            seen.zero_size   = rsp_chan.zero_size;
            rsp_seen++;
            moved = 1'b1;
            if (outcome_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("response %0d arrived with no request outstanding", rsp_seen);
            end else begin
               want = outcome_q.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"response %0d exp/act: found %b/%b index %0d/%0d ",
                               "inserted %b/%b full %b/%b zero %b/%b"},
                              rsp_seen, want.found, seen.found,
                              want.match_index, seen.match_index,
                              want.inserted, seen.inserted,
                              want.table_full, seen.table_full,
                              want.zero_size, seen.zero_size);
               end
            end
         end
         // watchdog
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin : sequence_proc
      int unsigned n;
      req_chan.valid         = 1'b0;
      req_chan.opcode        = OP_FIND;
      req_chan.ref_start     = '0;
      req_chan.ref_end       = '0;
      req_chan.qry_start     = '0;
      req_chan.qry_end       = '0;
      csr_chan.valid         = 1'b0;
      csr_chan.overlap_ratio = '0;
      rsp_chan.ready         = 1'b0;

      // directed, ratio at its reset value of one half
      add_request(OP_FIND,   32'd10, 32'd20, 32'd10, 32'd20);            // empty table
      add_request(OP_INSERT, 32'd5, 32'd5, 32'd1, 32'd9);                // zero-length reference
      add_request(OP_INSERT, 32'd1, 32'd9, 32'd9, 32'd3);                // reversed query
      add_request(OP_FIND,   32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF); // reversed reference
      add_request(OP_FIND,   32'h0, 32'h0, 32'h0, 32'h0);                // all zero
      add_request(OP_INSERT, 32'd1000, 32'd2000, 32'd1000, 32'd2000);    // first entry
      add_request(OP_INSERT, 32'd1000, 32'd2000, 32'd1000, 32'd2000);    // full overlap, appended
      add_request(OP_INSERT, 32'd1500, 32'd2500, 32'd1500, 32'd2500);    // exactly half, matches
      add_request(OP_INSERT, 32'd1499, 32'd2499, 32'd1499, 32'd2499);    // just over half
      add_request(OP_FIND,   32'd2000, 32'd4000, 32'd2000, 32'd4000);    // touching ends
      add_request(OP_INSERT, 32'd1000, 32'd2000, 32'd5000, 32'd6000);    // query apart
      add_request(OP_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      add_request(OP_FIND,   32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF); // whole range
      add_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      add_request(OP_INSERT, 32'd7, 32'd8, 32'd7, 32'd8);                // unit length
      add_request(OP_FIND,   32'd7, 32'd8, 32'd7, 32'd8);
      add_request(OP_FIND,   32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      add_request(OP_INSERT, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA);

      // ratio of exactly one: any intersecting entry qualifies
      add_ratio(17'd65536);
      repeat (55) add_random_request();
      add_drain();
      repeat (55) add_random_request();

      // ratio zero: only touching entries qualify, ladder pairs fill the table
      add_ratio('0);
      for (n = 0; n < 120; n++) begin
         if ($urandom_range(0, 5) == 0) add_random_request();
         else add_ladder_insert();
      end

      // ratio above one, taken as is
      add_ratio('1);
      repeat (70) add_random_request();

      // finish filling, then inserts get dropped as full
      add_ratio('0);
      for (n = 0; n < 180; n++) begin
         if ($urandom_range(0, 17) == 0) add_random_request();
         else add_ladder_insert();
      end

      add_ratio(RATIO_W'($urandom_range(0, 131071)));
      repeat (40) add_random_request();
      add_ratio(RATIO_W'($urandom_range(0, 131071)));
      repeat (40) add_random_request();

      while (!(stim_q.size() == 0 && req_issued == req_taken && csr_issued == csr_taken &&
               outcome_q.size() == 0))
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && outcome_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
